### rtl/core/l2ob_pkg.sv
// ----------------------------------------------------------------------------
// l2ob_pkg
// Shared types and constants for the level-2 order book block.
// ----------------------------------------------------------------------------
package l2ob_pkg;

    localparam int unsigned LEVELS_DEF = 64;

    typedef enum logic [1:0] {
        FN_APPLY       = 2'd0,
        FN_CLEAR_APPLY = 2'd1,
        FN_CLEAR       = 2'd2,
        FN_NONE        = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_MUL,
        ST_SQRT,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture item, apply clears
        logic search_go;  // start scan of selected side
        logic shift_go;   // start insert/delete shift
        logic mul_go;     // form bid*ask product
        logic sqrt_go;    // start root iterations
        logic emit;       // drive result strobe
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic do_apply;
        logic search_done;
        logic need_shift;
        logic shift_done;
        logic book_valid;
        logic sqrt_done;
    } t_status;

endpackage

### rtl/core/l2ob_ctrl.sv
// ----------------------------------------------------------------------------
// l2ob_ctrl
// Sequencer for one update: search, shift, multiply, square root, emit.
// ----------------------------------------------------------------------------
module l2ob_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  l2ob_pkg::t_status i_sts,
    output l2ob_pkg::t_cmd    o_cmd
);
    import l2ob_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) n_state = ST_SEARCH;
            ST_SEARCH: begin
                if (!i_sts.do_apply) begin
                    n_state = i_sts.book_valid ? ST_MUL : ST_DONE;
                end else if (i_sts.search_done) begin
                    if (i_sts.need_shift) n_state = ST_SHIFT;
                    else n_state = i_sts.book_valid ? ST_MUL : ST_DONE;
                end
            end
            ST_SHIFT:  if (i_sts.shift_done) n_state = i_sts.book_valid ? ST_MUL : ST_DONE;
            ST_MUL:    n_state = ST_SQRT;
            ST_SQRT:   if (i_sts.sqrt_done) n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_SEARCH: o_cmd.search_go = 1'b1;
            ST_SHIFT:  o_cmd.shift_go  = 1'b1;
            ST_MUL:    o_cmd.mul_go    = 1'b1;
            ST_SQRT:   o_cmd.sqrt_go   = 1'b1;
            ST_DONE:   o_cmd.emit      = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && start) |=> r_state == ST_SEARCH)
        else $error("accepted item did not enter search");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> !busy)
        else $error("block not idle after result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_SQRT))
        else $error("multiply not followed by root");
endmodule

### rtl/core/l2ob_dp.sv
// ----------------------------------------------------------------------------
// l2ob_dp
// Level tables, scan/shift engine, multiplier and integer square root.
// ----------------------------------------------------------------------------
module l2ob_dp #(
    parameter int unsigned LEVELS = l2ob_pkg::LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  l2ob_pkg::t_cmd    i_cmd,
    output l2ob_pkg::t_status o_sts,
    input  logic [1:0]        i_func,
    input  logic              i_is_bid,
    input  logic [31:0]       i_price_ticks,
    input  logic [31:0]       i_quantity_lots,
    output logic [31:0]       o_best_bid,
    output logic [31:0]       o_best_ask,
    output logic [31:0]       o_mid_price,
    output logic              o_ticker_valid,
    output logic              o_level_dropped,
    output logic              o_strobe
);
    import l2ob_pkg::*;

    localparam int unsigned AW = $clog2(LEVELS);
    localparam int unsigned CW = $clog2(LEVELS + 1);

    // memories: one per side, price and qty packed
    logic [63:0] bid_mem [LEVELS];
    logic [63:0] ask_mem [LEVELS];

    logic [CW-1:0] r_bid_cnt, r_ask_cnt;
    logic [31:0]   r_bid_top, r_ask_top;   // cached entry 0 prices
    logic          r_side, r_apply;
    logic [31:0]   r_price, r_qty;
    logic [CW-1:0] r_pos;      // scan / shift position
    logic [CW-1:0] r_ins;      // found position
    logic          r_found, r_sdone, r_need, r_del, r_shdone, r_drop;
    logic [63:0]   r_rd;       // registered read data
    logic          r_rdv;
    logic [63:0]   r_rem, r_res, r_bit;
    logic          r_sqdone;
    logic [31:0]   r_o_bb, r_o_ba, r_o_mid;
    logic          r_o_v, r_o_d, r_o_stb;

    logic [CW-1:0] cnt_sel;
    assign cnt_sel = r_side ? r_bid_cnt : r_ask_cnt;

    // read port address
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] rd_full;
    always_comb begin
        rd_full = r_pos;
        if (i_cmd.shift_go && !r_del) rd_full = r_pos - CW'(1);
        if (i_cmd.shift_go && r_del)  rd_full = r_pos + CW'(1);
        rd_addr = rd_full[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_side ? bid_mem[rd_addr] : ask_mem[rd_addr];
    end

    logic ahead;
    assign ahead = r_side ? (r_rd[63:32] > r_price) : (r_rd[63:32] < r_price);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_side) bid_mem[wr_addr] <= wr_data;
            else        ask_mem[wr_addr] <= wr_data;
        end
    end

    logic [63:0] sq_try;
    assign sq_try = r_res + r_bit;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pos[AW-1:0];
        wr_data = r_rd;
        if (i_cmd.search_go && r_sdone && !r_need && r_found && (r_qty != '0)) begin
            // existing level: overwrite quantity in place
            wr_en   = 1'b1;
            wr_addr = r_ins[AW-1:0];
            wr_data = {r_price, r_qty};
        end else if (i_cmd.shift_go && !r_shdone) begin
            if (r_del) begin
                // move entry pos+1 down to pos; read data is registered, so wait for r_rdv
                wr_en = r_rdv && (r_pos + CW'(1) < cnt_sel);
            end else if (r_pos == r_ins) begin
                wr_en   = 1'b1;
                wr_data = {r_price, r_qty};
            end else begin
                wr_en = r_rdv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bid_cnt <= '0;
            r_ask_cnt <= '0;
            r_o_stb   <= 1'b0;
            r_sdone   <= 1'b0;
            r_shdone  <= 1'b0;
            r_sqdone  <= 1'b0;
            r_rdv     <= 1'b0;
        end else begin
            r_o_stb <= i_cmd.emit;
            if (i_cmd.load) begin
                r_side  <= i_is_bid;
                r_price <= i_price_ticks;
                r_qty   <= i_quantity_lots;
                r_apply <= (i_func == FN_APPLY) || (i_func == FN_CLEAR_APPLY);
                if (i_func == FN_CLEAR_APPLY || i_func == FN_CLEAR) begin
                    r_bid_cnt <= '0;
                    r_ask_cnt <= '0;
                end
                r_pos    <= '0;
                r_sdone  <= 1'b0;
                r_shdone <= 1'b0;
                r_sqdone <= 1'b0;
                r_rdv    <= 1'b0;
                r_drop   <= 1'b0;
                r_need   <= 1'b0;
            end
            // scan: read pos, compare next cycle
            if (i_cmd.search_go && !r_sdone) begin
                if (!r_rdv) begin
                    r_rdv <= 1'b1;
                    if (cnt_sel == '0) begin
                        r_sdone <= 1'b1;
                        r_found <= 1'b0;
                        r_ins   <= '0;
                    end
                end else if (r_pos < cnt_sel && ahead) begin
                    r_pos <= r_pos + CW'(1);
                    r_rdv <= 1'b0;
                end else begin
                    r_sdone <= 1'b1;
                    r_ins   <= r_pos;
                    r_found <= (r_pos < cnt_sel) && (r_rd[63:32] == r_price);
                end
            end
            if (i_cmd.search_go && r_sdone && !r_need) begin
                // decide action once
                r_need <= 1'b1;
                r_rdv  <= 1'b0;
                if (r_found) begin
                    r_del <= (r_qty == '0);
                    if (r_qty != '0) begin
                        r_shdone <= 1'b1;
                    end else begin
                        r_pos <= r_ins;
                    end
                end else if (r_qty == '0) begin
                    r_shdone <= 1'b1;
                end else if (cnt_sel == CW'(LEVELS)) begin
                    r_drop   <= 1'b1;
                    r_shdone <= 1'b1;
                end else begin
                    r_del <= 1'b0;
                    r_pos <= cnt_sel;
                end
            end
            if (i_cmd.shift_go && !r_shdone) begin
                if (r_del) begin
                    if (r_pos + CW'(1) >= cnt_sel) begin
                        r_shdone <= 1'b1;
                        if (r_side) r_bid_cnt <= r_bid_cnt - CW'(1);
                        else        r_ask_cnt <= r_ask_cnt - CW'(1);
                    end else if (!r_rdv) begin
                        r_rdv <= 1'b1;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                        r_rdv <= 1'b0;
                    end
                end else if (r_pos == r_ins) begin
                    r_shdone <= 1'b1;
                    if (r_side) r_bid_cnt <= r_bid_cnt + CW'(1);
                    else        r_ask_cnt <= r_ask_cnt + CW'(1);
                end else if (!r_rdv) begin
                    r_rdv <= 1'b1;
                end else begin
                    r_pos <= r_pos - CW'(1);
                    r_rdv <= 1'b0;
                end
            end
            // multiply top prices (32x32), then seed root at 2^62
            if (i_cmd.mul_go) begin
                r_rem <= 64'(r_bid_top) * 64'(r_ask_top);
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            if (i_cmd.sqrt_go && !r_sqdone) begin
                if (r_bit == '0) begin
                    r_sqdone <= 1'b1;
                end else begin
                    if (r_rem >= sq_try) begin
                        r_rem <= r_rem - sq_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
        end
    end

    // cached best prices, refreshed from the tables each cycle of the top read
    logic [63:0] bid_top_rd, ask_top_rd;
    always_ff @(posedge i_clk) begin
        bid_top_rd <= bid_mem[0];
        ask_top_rd <= ask_mem[0];
    end
    assign r_bid_top = bid_top_rd[63:32];
    assign r_ask_top = ask_top_rd[63:32];

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_bb  <= (r_bid_cnt != '0) ? r_bid_top : '0;
            r_o_ba  <= (r_ask_cnt != '0) ? r_ask_top : '0;
            r_o_v   <= (r_bid_cnt != '0) && (r_ask_cnt != '0);
            r_o_mid <= ((r_bid_cnt != '0) && (r_ask_cnt != '0)) ? r_res[31:0] : '0;
            r_o_d   <= r_drop;
        end
    end

    assign o_sts.do_apply    = r_apply;
    assign o_sts.search_done = r_need;
    assign o_sts.need_shift  = !r_shdone;
    assign o_sts.shift_done  = r_shdone;
    assign o_sts.book_valid  = (r_bid_cnt != '0) && (r_ask_cnt != '0);
    assign o_sts.sqrt_done   = r_sqdone;

    assign o_best_bid      = r_o_bb;
    assign o_best_ask      = r_o_ba;
    assign o_mid_price     = r_o_mid;
    assign o_ticker_valid  = r_o_v;
    assign o_level_dropped = r_o_d;
    assign o_strobe        = r_o_stb;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bid_cnt <= CW'(LEVELS)) && (r_ask_cnt <= CW'(LEVELS)))
        else $error("level count beyond table depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_stb |=> !r_o_stb)
        else $error("result strobe longer than one cycle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_stb |-> (r_o_v || r_o_mid == '0))
        else $error("mid price without both sides");
endmodule

### rtl/core/l2_order_book_levels_top.sv
// ----------------------------------------------------------------------------
// l2_order_book_levels_top
// Level-2 price-level book with best bid/ask and geometric mid price.
// ----------------------------------------------------------------------------
// Usage: raise start with an item while busy is low; the item is taken at
// that edge. A level update scans its side over the levels ranked ahead of
// its price, then on insert or delete shifts the table one moved level at a
// time (scan and shift share one read address per side table); a clear or
// unknown code skips both. When both sides then hold levels, a multiply step
// and the square root follow (32 bit-pair iterations, a finish step and a
// handoff). An emit state closes the item. The result appears for exactly
// one cycle with o_valid in the cycle after emit, as busy drops; it cannot
// be stalled, so capture it.
module l2_order_book_levels_top #(
    parameter int unsigned LEVELS = l2ob_pkg::LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic        i_is_bid,
    input  logic [31:0] i_price_ticks,
    input  logic [31:0] i_quantity_lots,
    output logic        o_valid,
    output logic [31:0] o_best_bid,
    output logic [31:0] o_best_ask,
    output logic [31:0] o_mid_price,
    output logic        o_ticker_valid,
    output logic        o_level_dropped
);
    import l2ob_pkg::*;

    t_cmd    cmd;
    t_status sts;

    // sequence each item through its phases
    l2ob_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    // hold the tables and do the arithmetic
    l2ob_dp #(.LEVELS(LEVELS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_is_bid       (i_is_bid),
        .i_price_ticks  (i_price_ticks),
        .i_quantity_lots(i_quantity_lots),
        .o_best_bid     (o_best_bid),
        .o_best_ask     (o_best_ask),
        .o_mid_price    (o_mid_price),
        .o_ticker_valid (o_ticker_valid),
        .o_level_dropped(o_level_dropped),
        .o_strobe       (o_valid)
    );
endmodule

### bench/tb_l2_order_book_levels_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_l2_order_book_levels_top
// Drives level updates, book clears and idle codes into the order book block,
// keeps a behavioral copy of both price-sorted sides, and checks best bid,
// best ask, geometric mid, valid flag and drop flag on every result strobe.
// ----------------------------------------------------------------------------
import l2ob_pkg::*;

typedef struct {
    logic [31:0] best_bid;
    logic [31:0] best_ask;
    logic [31:0] mid_price;
    logic        ticker_valid;
    logic        level_dropped;
} t_ticker;

class ticker_scoreboard;
    logic [31:0] bid_px[$];
    logic [31:0] bid_qt[$];
    logic [31:0] ask_px[$];
    logic [31:0] ask_qt[$];
    t_ticker     pending[$];
    int          errors;

    function logic [31:0] root_floor(logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if ({32'd0, t} * {32'd0, t} <= v) r = t;
        end
        return r;
    endfunction

    // Apply one level to a side; return 1 when a new level is refused.
    function logic update_side(logic bid, logic [31:0] px, logic [31:0] qt);
        int n;
        int pos;
        n = bid ? bid_px.size() : ask_px.size();
        pos = 0;
        while (pos < n && (bid ? bid_px[pos] > px : ask_px[pos] < px)) pos++;
        if (pos < n && (bid ? bid_px[pos] : ask_px[pos]) == px) begin
            if (qt != 0) begin
                if (bid) bid_qt[pos] = qt; else ask_qt[pos] = qt;
            end else if (bid) begin
                bid_px.delete(pos); bid_qt.delete(pos);
            end else begin
                ask_px.delete(pos); ask_qt.delete(pos);
            end
            return 1'b0;
        end
        if (qt == 0) return 1'b0;
        if (n >= LEVELS_DEF) return 1'b1;
        if (bid) begin
            bid_px.insert(pos, px); bid_qt.insert(pos, qt);
        end else begin
            ask_px.insert(pos, px); ask_qt.insert(pos, qt);
        end
        return 1'b0;
    endfunction

    function void note_item(t_func fn, logic bid, logic [31:0] px, logic [31:0] qt);
        t_ticker e;
        e.level_dropped = 1'b0;
        if (fn == FN_CLEAR_APPLY || fn == FN_CLEAR) begin
            bid_px.delete(); bid_qt.delete(); ask_px.delete(); ask_qt.delete();
        end
        if (fn == FN_APPLY || fn == FN_CLEAR_APPLY) e.level_dropped = update_side(bid, px, qt);
        e.best_bid = bid_px.size() ? bid_px[0] : 32'd0;
        e.best_ask = ask_px.size() ? ask_px[0] : 32'd0;
        e.ticker_valid = bid_px.size() != 0 && ask_px.size() != 0;
        e.mid_price = e.ticker_valid ?
            root_floor({32'd0, e.best_bid} * {32'd0, e.best_ask}) : 32'd0;
        pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task check_ticker(t_ticker got);
        t_ticker e;
        if (pending.size() == 0) begin
            report("unexpected result", 32'd0, 32'd0); return;
        end
        e = pending.pop_front();
        if (got.best_bid !== e.best_bid) report("best_bid", got.best_bid, e.best_bid);
        if (got.best_ask !== e.best_ask) report("best_ask", got.best_ask, e.best_ask);
        if (got.mid_price !== e.mid_price) report("mid_price", got.mid_price, e.mid_price);
        if (got.ticker_valid !== e.ticker_valid)
            report("ticker_valid", 32'(got.ticker_valid), 32'(e.ticker_valid));
        if (got.level_dropped !== e.level_dropped)
            report("level_dropped", 32'(got.level_dropped), 32'(e.level_dropped));
    endtask
endclass

module tb_l2_order_book_levels_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic        i_is_bid;
    logic [31:0] i_price_ticks;
    logic [31:0] i_quantity_lots;
    logic        o_valid;
    logic [31:0] o_best_bid;
    logic [31:0] o_best_ask;
    logic [31:0] o_mid_price;
    logic        o_ticker_valid;
    logic        o_level_dropped;

    ticker_scoreboard book_sb;
    int unsigned      cycle_count;
    bit               quiet_tail;
    logic [31:0]      anchor;     // center of the price band for random updates
    logic [31:0]      recent_px[$];

    l2_order_book_levels_top u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: worst case is ~64 scanned and ~64 shifted levels plus the root
    // per item; the limit bounds the whole run, not each item.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 1500000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Capture every strobe at the edge that ends its cycle.
    always @(posedge i_clk) begin
        t_ticker got;
        if (i_rst_n && o_valid) begin
            got.best_bid      = o_best_bid;
            got.best_ask      = o_best_ask;
            got.mid_price     = o_mid_price;
            got.ticker_valid  = o_ticker_valid;
            got.level_dropped = o_level_dropped;
            book_sb.check_ticker(got);
        end
    end

    // Present one item, hold it until the block takes it, then drop start.
    task automatic send_item(t_func fn, logic bid, logic [31:0] px, logic [31:0] qt);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_func          <= fn;
        i_is_bid        <= bid;
        i_price_ticks   <= px;
        i_quantity_lots <= qt;
        do @(posedge i_clk); while (busy);
        book_sb.note_item(fn, bid, px, qt);
        start <= 1'b0;
        // Wait out the busy phase so start is never seen twice.
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Fill one side to capacity, push one more new level to force a drop, then update an existing level.
    task automatic fill_side(logic bid);
        for (int k = 0; k < LEVELS_DEF; k++)
            send_item(FN_APPLY, bid, 32'd1000 + k * 3, $urandom() | 32'd1);
        send_item(FN_APPLY, bid, 32'd5, 32'd9);
        send_item(FN_APPLY, bid, 32'd1000, 32'd77);  // existing level still updates
    endtask

    // Random item, mostly a level update near the anchor, often hitting known prices.
    task automatic random_update();
        t_func       fn;
        logic        bid;
        logic [31:0] px;
        logic [31:0] qt;
        int          r;
        r = $urandom_range(0, 99);
        fn = r < 3 ? FN_CLEAR : r < 6 ? FN_CLEAR_APPLY : r < 8 ? FN_NONE : FN_APPLY;
        bid = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        if (r < 4 && recent_px.size() != 0)
            px = recent_px[$urandom_range(0, recent_px.size() - 1)];
        else if (r < 9)
            px = bid ? anchor - $urandom_range(0, 60) : anchor + $urandom_range(0, 60);
        else
            px = $urandom();
        r = $urandom_range(0, 9);
        qt = r < 3 ? 32'd0 : r == 3 ? 32'hFFFF_FFFF : $urandom();
        if (recent_px.size() > 40) void'(recent_px.pop_front());
        recent_px.push_back(px);
        send_item(fn, bid, px, qt);
    endtask

    initial begin
        book_sb = new();
        quiet_tail      = 1'b0;
        start           = 1'b0;
        i_func          = FN_APPLY;
        i_is_bid        = 1'b0;
        i_price_ticks   = '0;
        i_quantity_lots = '0;
        i_rst_n         = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty book, price extremes, removal of absent levels,
        // unknown code, clear-then-apply and clear only.
        send_item(FN_NONE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FN_APPLY, 1'b0, 32'd7, 32'd0);
        send_item(FN_APPLY, 1'b1, 32'd0, 32'd1);
        send_item(FN_APPLY, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FN_APPLY, 1'b1, 32'hFFFF_FFFF, 32'd5);
        send_item(FN_APPLY, 1'b1, 32'hFFFF_FFFE, 32'd6);
        send_item(FN_APPLY, 1'b0, 32'h8000_0000, 32'd3);
        send_item(FN_APPLY, 1'b1, 32'hFFFF_FFFF, 32'd0);
        send_item(FN_APPLY, 1'b1, 32'd12345, 32'd0);
        send_item(FN_NONE, 1'b0, 32'd0, 32'd0);
        send_item(FN_CLEAR_APPLY, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(FN_APPLY, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(FN_APPLY, 1'b0, 32'd0, 32'd2);
        send_item(FN_CLEAR, 1'b1, 32'd1, 32'd1);
        fill_side(1'b1);
        fill_side(1'b0);
        send_item(FN_CLEAR, 1'b0, 32'd0, 32'd0);

        // Random: shifting price bands keep both sides busy and crossing.
        anchor = 32'd100000;
        for (int n = 0; n < 360; n++) begin
            if (n % 100 == 0) anchor = $urandom_range(200, 32'hFFFF_FF00);
            if (n >= 320) quiet_tail = 1'b1;
            random_update();
        end

        while (book_sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (book_sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### l2_order_book_levels_top.f
rtl/core/l2ob_pkg.sv
rtl/core/l2ob_ctrl.sv
rtl/core/l2ob_dp.sv
rtl/core/l2_order_book_levels_top.sv
bench/tb_l2_order_book_levels_top.sv
